FILE: sv/bbd_pkg.sv
// Shared constants and types of the BGGR bilinear demosaic block.
package bbd_pkg;

  // Line store geometry
  localparam int MAX_LINE = 512;
  localparam int LINE_AW  = $clog2(MAX_LINE);

  // Field widths
  localparam int SAMPLE_W = 8;
  localparam int COLOR_W  = 8;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 9;
  localparam int FW_W     = 10;
  localparam int FH_W     = 12;

  // Line store entry holds {older line, newer line}
  localparam int LINE_DW = 2 * SAMPLE_W;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(316);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(208);
  localparam logic [FW_W-1:0] FRAME_WIDTH_MIN  = FW_W'(3);
  localparam logic [FW_W-1:0] FRAME_WIDTH_MAX  = FW_W'(MAX_LINE);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_MIN = FH_W'(3);

  // Which copy of an edge position is being emitted
  typedef enum logic [1:0] {
    SEL_LOW  = 2'd0,
    SEL_MID  = 2'd1,
    SEL_HIGH = 2'd2
  } edge_sel_t;

endpackage

FILE: sv/bbd_if.sv
// Valid/ready channel interfaces for raw samples and RGB pixels.
interface bbd_sample_if;
  logic                          valid;
  logic                          ready;
  logic [bbd_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bbd_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [bbd_pkg::COLOR_W-1:0]   red;
  logic [bbd_pkg::COLOR_W-1:0]   green;
  logic [bbd_pkg::COLOR_W-1:0]   blue;
  logic [bbd_pkg::ROW_W-1:0]     pixel_row;
  logic [bbd_pkg::COL_W-1:0]     pixel_col;
  logic                          last_of_run;

  modport source (output valid, output red, output green, output blue,
                  output pixel_row, output pixel_col, output last_of_run,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input pixel_row, input pixel_col, input last_of_run,
                  output ready);
endinterface

FILE: sv/bayer_bggr_bilinear_demosaic.sv
// Streaming BGGR Bayer to RGB demosaic, bilinear over a 3x3 window. One raw
// sample is taken per cycle in raster order when not stalled. Each accepted
// sample reads the two previous lines at its column from one 512-entry
// line-store RAM with registered read data, and the older/newer pair is written
// back when the item moves into the window stage; consecutive samples always
// hit different columns, so no forwarding is needed. A result passes the input
// stage, the window stage and the output register. Inner pixels give one result
// per sample; a sample whose window centre sits next to a frame edge gives two,
// three, four, six or nine results, one per cycle while the output is not
// stalled, and the input waits until the last is loaded. Samples in the first
// two lines or columns give no result.
// Writing frame_width (address 0) or frame_height (address 4) restarts the
// frame at line 0, column 0; write only while the block is idle.
module bayer_bggr_bilinear_demosaic (
  input  logic                        clk,
  input  logic                        rst,
  bbd_sample_if.sink                  raw,
  bbd_pixel_if.source                 rgb,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbd_pkg::APB_AW-1:0]  paddr,
  input  logic [bbd_pkg::APB_DW-1:0]  pwdata,
  output logic [bbd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bbd_pkg::*;

  // Configuration registers
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            cfg_wr;
  logic [FW_W-1:0] eff_w;
  logic [FH_W-1:0] eff_h;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // Clamp the frame size to the supported range
  always_comb begin
    eff_w = frame_width;
    if (frame_width < FRAME_WIDTH_MIN) eff_w = FRAME_WIDTH_MIN;
    if (frame_width > FRAME_WIDTH_MAX) eff_w = FRAME_WIDTH_MAX;
    eff_h = frame_height;
    if (frame_height < FRAME_HEIGHT_MIN) eff_h = FRAME_HEIGHT_MIN;
  end

  // Handshake and stage control
  logic in_xfer;
  logic a_valid, a_advance;
  logic b_valid, b_free, b_fire_last;
  logic o_valid, out_load;
  logic run_last;

  assign in_xfer   = raw.valid && raw.ready;
  assign raw.ready = !a_valid || a_advance;
  assign a_advance = a_valid && b_free;

  // Position of the next sample
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_xfer) begin
      if ((FW_W'(col_count) + FW_W'(1)) >= eff_w) begin
        col_count <= '0;
        if (({1'b0, row_count} + (ROW_W+1)'(1)) >= {1'b0, eff_h}) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + ROW_W'(1);
        end
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // Line store: read at accept, write back on the way into the window stage
  logic [SAMPLE_W-1:0] a_sample;
  logic [ROW_W-1:0]    a_row;
  logic [COL_W-1:0]    a_col;
  logic [LINE_DW-1:0]  line_rdata;
  logic [SAMPLE_W-1:0] top, mid;

  bbd_ram #(
    .WIDTH (LINE_DW),
    .DEPTH (MAX_LINE)
  ) u_line_ram (
    .clk   (clk),
    .we    (a_advance),
    .waddr (a_col[LINE_AW-1:0]),
    .wdata ({mid, a_sample}),
    .re    (in_xfer),
    .raddr (col_count[LINE_AW-1:0]),
    .rdata (line_rdata)
  );

  assign top = line_rdata[LINE_DW-1:SAMPLE_W];
  assign mid = line_rdata[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_xfer) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_sample <= raw.sample;
      a_row    <= row_count;
      a_col    <= col_count;
    end
  end

  // Window stage: 3x3 window, rows top..bottom are win[0..2], [3..5], [6..8]
  logic [SAMPLE_W-1:0] win [9];
  logic                b_elig;
  logic [ROW_W-1:0]    b_yy;
  logic [COL_W-1:0]    b_xx;
  logic                b_ext_bot, b_ext_left, b_ext_right;
  edge_sel_t           b_ysel, b_xsel;
  logic [ROW_W-1:0]    a_yy;
  logic [COL_W-1:0]    a_xx;
  logic                a_ext_top, a_ext_left;

  assign a_yy       = a_row - ROW_W'(1);
  assign a_xx       = a_col - COL_W'(1);
  assign a_ext_top  = (a_yy == ROW_W'(1));
  assign a_ext_left = (a_xx == COL_W'(1));

  always_ff @(posedge clk) begin
    if (a_advance) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3+0] <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= top;
      win[5] <= mid;
      win[8] <= a_sample;
    end
  end

  assign b_fire_last = b_valid && (!b_elig || (out_load && run_last));
  assign b_free      = !b_valid || b_fire_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_advance) begin
      b_valid <= 1'b1;
    end else if (b_fire_last) begin
      b_valid <= 1'b0;
    end
  end

  // Edge copies to emit for this centre, and the walk through them
  logic y_last, x_last;

  assign y_last   = (b_ysel == SEL_HIGH) || ((b_ysel == SEL_MID) && !b_ext_bot);
  assign x_last   = (b_xsel == SEL_HIGH) || ((b_xsel == SEL_MID) && !b_ext_right);
  assign run_last = y_last && x_last;

  always_ff @(posedge clk) begin
    if (a_advance) begin
      b_elig      <= (a_row >= ROW_W'(2)) && (a_col >= COL_W'(2));
      b_yy        <= a_yy;
      b_xx        <= a_xx;
      b_ext_bot   <= (a_yy == (eff_h - FH_W'(2)));
      b_ext_left  <= a_ext_left;
      b_ext_right <= ({1'b0, a_xx} == (eff_w - FW_W'(2)));
      b_ysel      <= a_ext_top ? SEL_LOW : SEL_MID;
      b_xsel      <= a_ext_left ? SEL_LOW : SEL_MID;
    end else if (out_load) begin
      if (x_last) begin
        b_xsel <= b_ext_left ? SEL_LOW : SEL_MID;
        b_ysel <= (b_ysel == SEL_LOW) ? SEL_MID : SEL_HIGH;
      end else begin
        b_xsel <= (b_xsel == SEL_LOW) ? SEL_MID : SEL_HIGH;
      end
    end
  end

  // Bilinear interpolation by colour of the centre position
  logic [SAMPLE_W+1:0] cross_sum, diag_sum;
  logic [SAMPLE_W:0]   vert_sum, horz_sum;
  logic [COLOR_W-1:0]  cross_avg, diag_avg, vert_avg, horz_avg, ctr;
  logic [COLOR_W-1:0]  red_c, green_c, blue_c;

  assign cross_sum = (SAMPLE_W+2)'(win[1]) + (SAMPLE_W+2)'(win[7])
                   + (SAMPLE_W+2)'(win[3]) + (SAMPLE_W+2)'(win[5]);
  assign diag_sum  = (SAMPLE_W+2)'(win[0]) + (SAMPLE_W+2)'(win[2])
                   + (SAMPLE_W+2)'(win[6]) + (SAMPLE_W+2)'(win[8]);
  assign vert_sum  = (SAMPLE_W+1)'(win[1]) + (SAMPLE_W+1)'(win[7]);
  assign horz_sum  = (SAMPLE_W+1)'(win[3]) + (SAMPLE_W+1)'(win[5]);
  assign cross_avg = cross_sum[SAMPLE_W+1:2];
  assign diag_avg  = diag_sum[SAMPLE_W+1:2];
  assign vert_avg  = vert_sum[SAMPLE_W:1];
  assign horz_avg  = horz_sum[SAMPLE_W:1];
  assign ctr       = win[4];

  always_comb begin
    case ({b_yy[0], b_xx[0]})
      2'b11: begin   // red site
        red_c = ctr;       green_c = cross_avg; blue_c = diag_avg;
      end
      2'b10: begin   // green site on a red line
        red_c = horz_avg;  green_c = ctr;       blue_c = vert_avg;
      end
      2'b01: begin   // green site on a blue line
        red_c = vert_avg;  green_c = ctr;       blue_c = horz_avg;
      end
      default: begin // blue site
        red_c = diag_avg;  green_c = cross_avg; blue_c = ctr;
      end
    endcase
  end

  // Output register
  logic [ROW_W-1:0] row_c;
  logic [COL_W-1:0] col_c;

  always_comb begin
    case (b_ysel)
      SEL_LOW:  row_c = '0;
      SEL_MID:  row_c = b_yy;
      default:  row_c = eff_h - FH_W'(1);
    endcase
    case (b_xsel)
      SEL_LOW:  col_c = '0;
      SEL_MID:  col_c = b_xx;
      default:  col_c = COL_W'(eff_w - FW_W'(1));
    endcase
  end

  assign out_load = b_valid && b_elig && (!o_valid || rgb.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (rgb.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rgb.red         <= red_c;
      rgb.green       <= green_c;
      rgb.blue        <= blue_c;
      rgb.pixel_row   <= row_c;
      rgb.pixel_col   <= col_c;
      rgb.last_of_run <= run_last;
    end
  end

  assign rgb.valid = o_valid;

endmodule

FILE: sv/bbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/bbd_checker.sv
// Port-level checks for the demosaic block, bound to its top level.
module bbd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bbd_pkg::COLOR_W-1:0] red,
  input logic [bbd_pkg::COLOR_W-1:0] green,
  input logic [bbd_pkg::COLOR_W-1:0] blue,
  input logic [bbd_pkg::ROW_W-1:0]   pixel_row,
  input logic [bbd_pkg::COL_W-1:0]   pixel_col,
  input logic                        last_of_run,
  input logic                        pready
);

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its position
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pixel_row) && $stable(pixel_col))
    else $error("stalled result changed position");

  // Within a run the next result follows at once with the same colour
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=>
      out_valid && red == $past(red) && green == $past(green) && blue == $past(blue))
    else $error("run broken or colour changed within a run");

  // Nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // The configuration port never waits
  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind bayer_bggr_bilinear_demosaic bbd_checker u_bbd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (rgb.valid),
  .out_ready   (rgb.ready),
  .red         (rgb.red),
  .green       (rgb.green),
  .blue        (rgb.blue),
  .pixel_row   (rgb.pixel_row),
  .pixel_col   (rgb.pixel_col),
  .last_of_run (rgb.last_of_run),
  .pready      (pready)
);
